[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the power five twelfths core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off during reset, fixed message
`define PFC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfc assertion failed");

// Clocked assertion, held off during reset, caller message
`define PFC_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

[hw/rtl/pfc_pkg.sv]
// Package for the power five twelfths core: widths, stage map, constant
// tables and fixed-point helper functions. Depends on nothing.
`default_nettype none

package pfc_pkg;

    // Field and datapath widths
    localparam int X_W    = 32;           // input Q1.31
    localparam int Y_W    = 32;           // result Q1.31
    localparam int LZ_W   = 5;            // leading zero count of x
    localparam int FRAC_W = 32;           // Q.32 fraction bits
    localparam int VAL_W  = 36;           // signed Q.32 datapath values
    localparam int MAG_W  = 34;           // multiplier operand magnitude
    localparam int PROD_W = 2 * MAG_W;    // full magnitude product
    localparam int SCL_W  = 40;           // scaled result before final shift
    localparam int K_W    = 2;            // exponent quotient
    localparam int R_W    = 4;            // exponent remainder

    localparam int SERIES_N = 9;
    localparam int EXP_DEN  = 12;
    localparam int SCALE_N  = EXP_DEN;

    // Stage map: input, normalise, seven recurrence steps of two stages,
    // last two series terms, scaling, final shift
    localparam int STG_IN     = 0;
    localparam int STG_NORM   = 1;
    localparam int STG_TAIL_M = 16;
    localparam int STG_TAIL_A = 17;
    localparam int STG_SCL_M  = 18;
    localparam int STG_SCL_A  = 19;
    localparam int STG_OUT    = 20;
    localparam int PIPE_DEPTH = 21;

    localparam logic [63:0] DEC18 = 64'd1000000000000000000;

    localparam logic signed [VAL_W-1:0] ONE_Q32   = 36'sd4294967296;
    localparam logic signed [VAL_W-1:0] THREE_Q32 = 36'sd12884901888;
    localparam logic [PROD_W-1:0]       HALF_Q32  = PROD_W'(64'h8000_0000);

    // Upper bound on any result: 1.34 in Q1.31
    localparam logic [Y_W-1:0] Y_MAX = 32'hAB85_1EB8;

    // Decimal constant (integer part, 18 fraction digits) to Q.32 magnitude,
    // rounded to nearest. Used on constants only.
    function automatic logic [63:0] dec_to_q32(input logic [63:0] ipart,
                                               input logic [63:0] frac18);
        logic [63:0] rem;
        logic [63:0] acc;
        begin
            rem = frac18;
            acc = '0;
            for (int i = 0; i < FRAC_W; i++) begin
                rem = rem << 1;
                acc = acc << 1;
                if (rem >= DEC18) begin
                    acc = acc | 64'd1;
                    rem = rem - DEC18;
                end
            end
            if ((rem << 1) >= DEC18) begin
                acc = acc + 64'd1;
            end
            return (ipart << FRAC_W) + acc;
        end
    endfunction

    // Series coefficient magnitudes and signs
    localparam logic [63:0] SERIES_MAG [SERIES_N] = '{
        dec_to_q32(64'd1, 64'd175820023299690192),
        dec_to_q32(64'd0, 64'd166657630948890612),
        dec_to_q32(64'd0, 64'd8315489493904213),
        dec_to_q32(64'd0, 64'd751879767804203),
        dec_to_q32(64'd0, 64'd83240178519392),
        dec_to_q32(64'd0, 64'd10229209410070),
        dec_to_q32(64'd0, 64'd1340046640986),
        dec_to_q32(64'd0, 64'd183334222416),
        dec_to_q32(64'd0, 64'd25878596761)
    };
    localparam logic SERIES_NEG [SERIES_N] = '{
        1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
    };

    // 2^(5r/12) for r = 0..11
    localparam logic [63:0] SCALE_Q32 [SCALE_N] = '{
        dec_to_q32(64'd1,  64'd0),
        dec_to_q32(64'd1,  64'd334839854170034368),
        dec_to_q32(64'd1,  64'd781797436280678548),
        dec_to_q32(64'd2,  64'd378414230005442054),
        dec_to_q32(64'd3,  64'd174802103936399167),
        dec_to_q32(64'd4,  64'd237852377437181239),
        dec_to_q32(64'd5,  64'd656854249492380582),
        dec_to_q32(64'd7,  64'd550994501453548224),
        dec_to_q32(64'd10, 64'd79368399158985525),
        dec_to_q32(64'd13, 64'd454342644059433809),
        dec_to_q32(64'd17, 64'd959392772949968275),
        dec_to_q32(64'd23, 64'd972913230026907883)
    };

    // One pipeline stage; each stage uses the fields it needs
    typedef struct packed {
        logic [X_W-1:0]          x;
        logic [LZ_W-1:0]         lz;
        logic                    zero;     // result forced to zero
        logic [K_W-1:0]          k;
        logic [R_W-1:0]          r;
        logic signed [VAL_W-1:0] two_t;
        logic signed [VAL_W-1:0] t_cur;
        logic signed [VAL_W-1:0] t_prev;
        logic signed [VAL_W-1:0] sum;
        logic [PROD_W-1:0]       p_a;
        logic [PROD_W-1:0]       p_b;
        logic                    neg_a;
        logic                    neg_b;
        logic [SCL_W-1:0]        scaled;
        logic [Y_W-1:0]          y;
    } stage_t;

    // Leading zero count; zero input gives 0, flagged separately
    function automatic logic [LZ_W-1:0] lead_zeros(input logic [X_W-1:0] v);
        logic [LZ_W-1:0] n;
        begin
            n = '0;
            for (int i = 0; i < X_W; i++) begin
                if (v[i]) begin
                    n = LZ_W'(X_W - 1 - i);
                end
            end
            return n;
        end
    endfunction

    // Exponent split: k = ceil(lz/12), r = 12k - lz, packed as {k, r}
    function automatic logic [K_W+R_W-1:0] exp_split(input logic [LZ_W-1:0] lz);
        logic [K_W-1:0] k;
        logic [5:0]     rw;
        begin
            if (lz == '0) begin
                k = 2'd0;
            end else if (lz <= LZ_W'(EXP_DEN)) begin
                k = 2'd1;
            end else if (lz <= LZ_W'(2 * EXP_DEN)) begin
                k = 2'd2;
            end else begin
                k = 2'd3;
            end
            rw = 6'(k) * 6'(EXP_DEN) - {1'b0, lz};
            return {k, rw[R_W-1:0]};
        end
    endfunction

    // Magnitude of a signed datapath value, cut to multiplier width
    function automatic logic [MAG_W-1:0] mag_of(input logic signed [VAL_W-1:0] a);
        logic [VAL_W-1:0] u;
        begin
            u = a[VAL_W-1] ? -a : a;
            return u[MAG_W-1:0];
        end
    endfunction

    // Unsigned magnitude multiply
    function automatic logic [PROD_W-1:0] mul_mag(input logic [MAG_W-1:0] a,
                                                  input logic [MAG_W-1:0] b);
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    // Q.32 product magnitude rounded half up, then signed
    function automatic logic signed [VAL_W-1:0] round_q32(input logic [PROD_W-1:0] p,
                                                          input logic neg);
        logic [PROD_W:0]  s;
        logic [VAL_W-1:0] m;
        begin
            s = {1'b0, p} + {1'b0, HALF_Q32};
            m = s[VAL_W+FRAC_W-1:FRAC_W];
            return neg ? -$signed(m) : $signed(m);
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/power_five_twelfths_chebyshev_core.sv]
// Takes one x item per cycle while x_stall is low; the depth is set by the
// seven chained Chebyshev recurrence steps, each one multiply stage and one
// add stage.
// Each stage holds when the stage after it is full and stalled, so bubbles
// close up and a stalled result waits in the output register.
// Reset clears the valid bits only; payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"

module power_five_twelfths_chebyshev_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      x_valid,
    output logic                           x_stall,
    input  wire logic [pfc_pkg::X_W-1:0]   x_value,
    output logic                           y_valid,
    input  wire logic                      y_stall,
    output logic [pfc_pkg::Y_W-1:0]        y_value
);

    pfc_pkg::stage_t                  pipe_reg  [pfc_pkg::PIPE_DEPTH];
    pfc_pkg::stage_t                  pipe_next [pfc_pkg::PIPE_DEPTH];
    logic [pfc_pkg::PIPE_DEPTH-1:0]   valid_reg;
    logic [pfc_pkg::PIPE_DEPTH-1:0]   valid_next;
    logic [pfc_pkg::PIPE_DEPTH:0]     rdy;

    // Stage ready: load when empty or when the next stage loads
    always_comb
    begin
        rdy[pfc_pkg::PIPE_DEPTH] = ~y_stall;
        for (int i = pfc_pkg::PIPE_DEPTH - 1; i >= 0; i--)
        begin
            rdy[i] = ~valid_reg[i] | rdy[i+1];
        end
    end

    // Valid bits travel with the data
    always_comb
    begin
        valid_next[0] = rdy[0] ? x_valid : valid_reg[0];
        for (int i = 1; i < pfc_pkg::PIPE_DEPTH; i++)
        begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < pfc_pkg::PIPE_DEPTH; i++)
        begin
            if (rdy[i])
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // Stage datapath
    always_comb
    begin
        logic [pfc_pkg::X_W-1:0]      mant;
        logic signed [pfc_pkg::VAL_W-1:0] t;
        logic [pfc_pkg::K_W+pfc_pkg::R_W-1:0] kr;
        logic [pfc_pkg::MAG_W-1:0]    s_mag;
        logic [63:0]                  scl;
        logic [4:0]                   sh;
        logic [pfc_pkg::SCL_W:0]      rnd;
        pfc_pkg::stage_t              src;

        // Input: capture x, leading zeros, zero flag
        pipe_next[pfc_pkg::STG_IN]      = '0;
        pipe_next[pfc_pkg::STG_IN].x    = x_value;
        pipe_next[pfc_pkg::STG_IN].lz   = pfc_pkg::lead_zeros(x_value);
        pipe_next[pfc_pkg::STG_IN].zero = (x_value == '0);

        // Normalise: mantissa, t = 4m - 3, exponent split, T0 and T1
        src  = pipe_reg[pfc_pkg::STG_IN];
        mant = src.x << src.lz;
        t    = $signed({2'b00, mant, 2'b00}) - pfc_pkg::THREE_Q32;
        kr   = pfc_pkg::exp_split(src.lz);
        pipe_next[pfc_pkg::STG_NORM]        = src;
        pipe_next[pfc_pkg::STG_NORM].k      = kr[pfc_pkg::K_W+pfc_pkg::R_W-1:pfc_pkg::R_W];
        pipe_next[pfc_pkg::STG_NORM].r      = kr[pfc_pkg::R_W-1:0];
        pipe_next[pfc_pkg::STG_NORM].two_t  = t <<< 1;
        pipe_next[pfc_pkg::STG_NORM].t_cur  = t;
        pipe_next[pfc_pkg::STG_NORM].t_prev = pfc_pkg::ONE_Q32;
        pipe_next[pfc_pkg::STG_NORM].sum    = '0;

        // Recurrence steps j = 2..8: multiply stage, then add stage
        for (int j = 2; j < pfc_pkg::SERIES_N; j++)
        begin
            // 2t * T(j-1) and c(j-2) * T(j-2)
            src = pipe_reg[2*j-3];
            pipe_next[2*j-2]       = src;
            pipe_next[2*j-2].p_a   = pfc_pkg::mul_mag(pfc_pkg::mag_of(src.two_t),
                                                      pfc_pkg::mag_of(src.t_cur));
            pipe_next[2*j-2].neg_a = src.two_t[pfc_pkg::VAL_W-1] ^ src.t_cur[pfc_pkg::VAL_W-1];
            pipe_next[2*j-2].p_b   = pfc_pkg::mul_mag(
                                         pfc_pkg::SERIES_MAG[j-2][pfc_pkg::MAG_W-1:0],
                                         pfc_pkg::mag_of(src.t_prev));
            pipe_next[2*j-2].neg_b = pfc_pkg::SERIES_NEG[j-2] ^ src.t_prev[pfc_pkg::VAL_W-1];

            // T(j) = 2t*T(j-1) - T(j-2); accumulate the series term
            src = pipe_reg[2*j-2];
            pipe_next[2*j-1]        = src;
            pipe_next[2*j-1].t_cur  = pfc_pkg::round_q32(src.p_a, src.neg_a) - src.t_prev;
            pipe_next[2*j-1].t_prev = src.t_cur;
            pipe_next[2*j-1].sum    = src.sum + pfc_pkg::round_q32(src.p_b, src.neg_b);
        end

        // Last two series terms: c8 * T8 and c7 * T7
        src = pipe_reg[pfc_pkg::STG_TAIL_M-1];
        pipe_next[pfc_pkg::STG_TAIL_M]       = src;
        pipe_next[pfc_pkg::STG_TAIL_M].p_a   = pfc_pkg::mul_mag(
            pfc_pkg::SERIES_MAG[pfc_pkg::SERIES_N-1][pfc_pkg::MAG_W-1:0],
            pfc_pkg::mag_of(src.t_cur));
        pipe_next[pfc_pkg::STG_TAIL_M].neg_a =
            pfc_pkg::SERIES_NEG[pfc_pkg::SERIES_N-1] ^ src.t_cur[pfc_pkg::VAL_W-1];
        pipe_next[pfc_pkg::STG_TAIL_M].p_b   = pfc_pkg::mul_mag(
            pfc_pkg::SERIES_MAG[pfc_pkg::SERIES_N-2][pfc_pkg::MAG_W-1:0],
            pfc_pkg::mag_of(src.t_prev));
        pipe_next[pfc_pkg::STG_TAIL_M].neg_b =
            pfc_pkg::SERIES_NEG[pfc_pkg::SERIES_N-2] ^ src.t_prev[pfc_pkg::VAL_W-1];

        src = pipe_reg[pfc_pkg::STG_TAIL_M];
        pipe_next[pfc_pkg::STG_TAIL_A]     = src;
        pipe_next[pfc_pkg::STG_TAIL_A].sum = src.sum
                                           + pfc_pkg::round_q32(src.p_a, src.neg_a)
                                           + pfc_pkg::round_q32(src.p_b, src.neg_b);

        // Scale: series times 2^(5r/12), split into fraction and integer parts
        src   = pipe_reg[pfc_pkg::STG_TAIL_A];
        s_mag = pfc_pkg::mag_of(src.sum);
        scl   = pfc_pkg::SCALE_Q32[src.r];
        pipe_next[pfc_pkg::STG_SCL_M]      = src;
        pipe_next[pfc_pkg::STG_SCL_M].p_a  = pfc_pkg::mul_mag(
            pfc_pkg::MAG_W'(scl[pfc_pkg::FRAC_W-1:0]), s_mag);
        pipe_next[pfc_pkg::STG_SCL_M].p_b  = pfc_pkg::mul_mag(
            pfc_pkg::MAG_W'(scl[pfc_pkg::FRAC_W+4:pfc_pkg::FRAC_W]), s_mag);
        // a series sum that is not positive gives zero
        pipe_next[pfc_pkg::STG_SCL_M].zero = src.zero | src.sum[pfc_pkg::VAL_W-1]
                                           | (src.sum == '0);

        src = pipe_reg[pfc_pkg::STG_SCL_M];
        pipe_next[pfc_pkg::STG_SCL_A]        = src;
        pipe_next[pfc_pkg::STG_SCL_A].scaled =
            pfc_pkg::SCL_W'(src.p_b)
            + pfc_pkg::SCL_W'((src.p_a + pfc_pkg::HALF_Q32) >> pfc_pkg::FRAC_W);

        // Final shift by 1 + 5k with half-up rounding, saturate
        src = pipe_reg[pfc_pkg::STG_SCL_A];
        sh  = 5'd1 + 5'(src.k) * 5'd5;
        rnd = ({1'b0, src.scaled} + ((pfc_pkg::SCL_W+1)'(1) << (sh - 5'd1))) >> sh;
        pipe_next[pfc_pkg::STG_OUT] = src;
        if (src.zero)
        begin
            pipe_next[pfc_pkg::STG_OUT].y = '0;
        end
        else if (|rnd[pfc_pkg::SCL_W:pfc_pkg::Y_W])
        begin
            pipe_next[pfc_pkg::STG_OUT].y = '1;
        end
        else
        begin
            pipe_next[pfc_pkg::STG_OUT].y = rnd[pfc_pkg::Y_W-1:0];
        end
    end

    // Ports
    assign x_stall = ~rdy[0];
    assign y_valid = valid_reg[pfc_pkg::STG_OUT];
    assign y_value = pipe_reg[pfc_pkg::STG_OUT].y;

    // Input stalls only when every stage is full and the output is held
    `PFC_ASSERT_MSG(a_stall_full, x_stall |-> ((&valid_reg) && y_stall), "stall with room")

    // Exponent remainder stays within the scale table
    `PFC_ASSERT(a_r_range, valid_reg[pfc_pkg::STG_NORM] |-> (pipe_reg[pfc_pkg::STG_NORM].r <= pfc_pkg::R_W'(pfc_pkg::EXP_DEN - 1)))

    // x^(5/12) stays below 1.34
    `PFC_ASSERT_MSG(a_y_bound, y_valid |-> (y_value <= pfc_pkg::Y_MAX), "result out of range")

    // Items in flight change only by accepted inputs and delivered results
    `PFC_ASSERT_MSG(a_item_count, $past(rst_n) |-> ($countones(valid_reg) == $past($countones(valid_reg)) + $past(x_valid && !x_stall) - $past(y_valid && !y_stall)), "item lost or repeated")

endmodule

`default_nettype wire

[bench/power_five_twelfths_chebyshev_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for power_five_twelfths_chebyshev_core: x^(5/12) on Q1.31 items.
// Depends on pfc_pkg for the widths and on the core itself; nothing else.

module power_five_twelfths_chebyshev_core_tb;

    typedef logic signed [63:0] q32_t;

    localparam q32_t Q_ONE       = 64'sh1_0000_0000;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   DRAIN_WAIT  = 30;     // pipeline latency plus margin
    localparam int   HOLD_LEN    = 150;    // long output hold-off, in cycles
    localparam int   HOLD_AFTER  = 200;    // results seen before the hold starts
    localparam int   PHASE_ITEMS = 445;
    localparam int   REPORT_MAX  = 10;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    x_valid = 1'b0;
    logic                    x_stall;
    logic [pfc_pkg::X_W-1:0] x_value = '0;
    logic                    y_valid;
    logic                    y_stall = 1'b0;
    logic [pfc_pkg::Y_W-1:0] y_value;

    // Item queues and bookkeeping
    logic [pfc_pkg::X_W-1:0] x_pending [$];
    logic [pfc_pkg::Y_W-1:0] y_expected [$];
    logic [pfc_pkg::Y_W-1:0] y_want;
    q32_t           cheb_coef [9];
    q32_t           octave_gain [12];
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             x_count = 0;
    int             y_count = 0;
    int             x_held_cycles = 0;
    int             rx_seen = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;
    int             mismatches = 0;
    int             cycle_count = 0;

    power_five_twelfths_chebyshev_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .x_valid (x_valid),
        .x_stall (x_stall),
        .x_value (x_value),
        .y_valid (y_valid),
        .y_stall (y_stall),
        .y_value (y_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Decimal constant (whole part, 18 fraction digits) to Q.32, nearest
    function automatic q32_t q32_const(input logic [63:0] whole, input logic [63:0] frac18,
                                       input bit neg);
        logic [127:0] scaled;
        q32_t         mag;
        scaled = ({64'd0, frac18} << 32) + 128'd500000000000000000;
        scaled = scaled / 128'd1000000000000000000;
        mag = q32_t'((whole << 32) + scaled[63:0]);
        return neg ? -mag : mag;
    endfunction

    // Q.32 product, magnitude rounded half up, sign applied afterwards
    function automatic q32_t q32_mul(input q32_t a, input q32_t b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        q32_t         m;
        ma = a[63] ? 64'(-a) : 64'(a);
        mb = b[63] ? 64'(-b) : 64'(b);
        p = {64'd0, ma} * {64'd0, mb} + 128'h8000_0000;
        m = {1'b0, p[94:32]};
        return (a[63] ^ b[63]) ? -m : m;
    endfunction

    // Expected y for one x: normalise, Chebyshev series, octave scaling
    function automatic logic [pfc_pkg::Y_W-1:0] pow_five_twelfths(
        input logic [pfc_pkg::X_W-1:0] x);
        int unsigned lz;
        int unsigned octave;
        int unsigned gain_idx;
        int unsigned sh;
        int          i;
        logic [31:0] mant;
        q32_t        t;
        q32_t        two_t;
        q32_t        t_km2;
        q32_t        t_km1;
        q32_t        t_k;
        q32_t        series;
        q32_t        scaled;
        logic [63:0] rounded;
        if (x == '0)
        begin
            return '0;
        end
        lz = 0;
        while (!x[31 - lz])
        begin
            lz++;
        end
        mant = x << lz;
        t = $signed({30'd0, mant, 2'b00}) - 3 * Q_ONE;
        two_t = t <<< 1;
        t_km2 = Q_ONE;
        t_km1 = t;
        series = q32_mul(cheb_coef[0], t_km2) + q32_mul(cheb_coef[1], t_km1);
        for (i = 2; i < 9; i++)
        begin
            t_k = q32_mul(two_t, t_km1) - t_km2;
            series += q32_mul(cheb_coef[i], t_k);
            t_km2 = t_km1;
            t_km1 = t_k;
        end
        octave = (lz + 11) / 12;
        gain_idx = (12 * octave - lz) % 12;
        scaled = q32_mul(octave_gain[gain_idx], series);
        sh = 1 + 5 * octave;
        if (scaled <= 0)
        begin
            return '0;
        end
        rounded = (64'(scaled) + (64'd1 << (sh - 1))) >> sh;
        if (rounded > 64'hFFFF_FFFF)
        begin
            return '1;
        end
        return rounded[31:0];
    endfunction

    // Random x: mostly spread over every leading-zero count, some raw, a few zeros
    function automatic logic [pfc_pkg::X_W-1:0] random_x();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 2)
        begin
            return '0;
        end
        if (sel < 20)
        begin
            return $urandom;
        end
        return {1'b1, 31'($urandom)} >> $urandom_range(31);
    endfunction

    task automatic note_mismatch(input string what, input logic [pfc_pkg::Y_W-1:0] want,
                                 input logic [pfc_pkg::Y_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("[%0t] %s: expected y %h, got %h", $time, what, want, got);
        end
    endtask

    task automatic wait_drained();
        while (x_pending.size() != 0 || x_valid || y_expected.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Sender: offers pending items, holds a stalled item unchanged
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            x_valid <= 1'b0;
            x_value <= '0;
        end
        else
        begin
            if (x_valid && !x_stall)
            begin
                y_expected.push_back(pow_five_twelfths(x_value));
                x_count++;
            end
            if (x_valid && x_stall)
            begin
                x_held_cycles++;
            end
            else if (x_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                x_valid <= 1'b1;
                x_value <= x_pending.pop_front();
            end
            else
            begin
                x_valid <= 1'b0;
                x_value <= $urandom;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off once enough results are in
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            y_stall <= 1'b0;
        end
        else
        begin
            if (y_valid && !y_stall)
            begin
                rx_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                y_stall <= 1'b1;
            end
            else if (!hold_done && rx_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                y_stall <= 1'b1;
            end
            else
            begin
                y_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && y_valid && !y_stall)
        begin
            y_count++;
            if (y_expected.size() == 0)
            begin
                note_mismatch("unexpected item", '0, y_value);
            end
            else
            begin
                y_want = y_expected.pop_front();
                if (y_value !== y_want)
                begin
                    note_mismatch("y_value", y_want, y_value);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles: %0d items in, %0d out",
                     cycle_count, x_count, y_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus and phase control
    initial
    begin
        int ph;
        int j;
        int lz;
        // series coefficients, signs alternating from the third term
        cheb_coef[0] = q32_const(64'd1, 64'd175820023299690192, 1'b0);
        cheb_coef[1] = q32_const(64'd0, 64'd166657630948890612, 1'b0);
        cheb_coef[2] = q32_const(64'd0, 64'd8315489493904213, 1'b1);
        cheb_coef[3] = q32_const(64'd0, 64'd751879767804203, 1'b0);
        cheb_coef[4] = q32_const(64'd0, 64'd83240178519392, 1'b1);
        cheb_coef[5] = q32_const(64'd0, 64'd10229209410070, 1'b0);
        cheb_coef[6] = q32_const(64'd0, 64'd1340046640986, 1'b1);
        cheb_coef[7] = q32_const(64'd0, 64'd183334222416, 1'b0);
        cheb_coef[8] = q32_const(64'd0, 64'd25878596761, 1'b1);
        // 2^(5r/12)
        octave_gain[0]  = q32_const(64'd1,  64'd0, 1'b0);
        octave_gain[1]  = q32_const(64'd1,  64'd334839854170034368, 1'b0);
        octave_gain[2]  = q32_const(64'd1,  64'd781797436280678548, 1'b0);
        octave_gain[3]  = q32_const(64'd2,  64'd378414230005442054, 1'b0);
        octave_gain[4]  = q32_const(64'd3,  64'd174802103936399167, 1'b0);
        octave_gain[5]  = q32_const(64'd4,  64'd237852377437181239, 1'b0);
        octave_gain[6]  = q32_const(64'd5,  64'd656854249492380582, 1'b0);
        octave_gain[7]  = q32_const(64'd7,  64'd550994501453548224, 1'b0);
        octave_gain[8]  = q32_const(64'd10, 64'd79368399158985525, 1'b0);
        octave_gain[9]  = q32_const(64'd13, 64'd454342644059433809, 1'b0);
        octave_gain[10] = q32_const(64'd17, 64'd959392772949968275, 1'b0);
        octave_gain[11] = q32_const(64'd23, 64'd972913230026907883, 1'b0);

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero, full scale, every exponent remainder, octave edges
        send_idle_pct = 22;
        recv_stall_pct = 59;
        x_pending.push_back(32'h0000_0000);
        x_pending.push_back(32'hFFFF_FFFF);
        x_pending.push_back(32'h7FFF_FFFF);
        x_pending.push_back(32'hAAAA_AAAA);
        x_pending.push_back(32'h5555_5555);
        x_pending.push_back(32'h0000_0003);
        for (lz = 0; lz < 12; lz++)
        begin
            x_pending.push_back(32'h8000_0000 >> lz);
        end
        x_pending.push_back(32'h0008_0000);
        x_pending.push_back(32'h0007_FFFF);
        x_pending.push_back(32'h0000_0080);
        x_pending.push_back(32'h0000_007F);
        x_pending.push_back(32'h0000_0040);
        x_pending.push_back(32'h0000_0001);
        wait_drained();

        // Random phases: sender slack / receiver busy, swapped, then flat out
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 22;
                    recv_stall_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_stall_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (j = 0; j < PHASE_ITEMS; j++)
            begin
                x_pending.push_back(random_x());
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(negedge clk);
        if (y_expected.size() != 0)
        begin
            mismatches += y_expected.size();
        end
        $display("Covered %0d x items and %0d y items, zero and all octaves included;",
                 x_count, y_count);
        $display("input held off for %0d cycles, one %0d-cycle output hold-off.",
                 x_held_cycles, HOLD_LEN);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pfc_pkg.sv
hw/rtl/power_five_twelfths_chebyshev_core.sv
bench/power_five_twelfths_chebyshev_core_tb.sv
